[rtl/cmc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_pkg
// Shared types, constants and helpers for the contact point merge cache:
// transfer payloads, the probe that walks the cell chain and the write-back.
// ----------------------------------------------------------------------------
package cmc_pkg;

   localparam int MAX_SLOTS = 4;
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
   localparam int THR_W     = 31;
   localparam int SQ_W      = 2 * THR_W;

   localparam logic [THR_W-1:0] THR_RESET = 31'd1311;
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_SLOTS - 1);

   localparam logic [31:0] HASH_X = 32'd73856093;
   localparam logic [31:0] HASH_Y = 32'd19349663;
   localparam logic [31:0] HASH_Z = 32'd83492791;

   typedef struct packed {
      logic               first;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] depth_in;
   } cmc_req_type;

   typedef struct packed {
      logic [1:0]         slot;
      logic               merged;
      logic               replaced;
      logic [31:0]        point_id;
      logic signed [31:0] stored_depth;
      logic [2:0]         point_count;
   } cmc_rsp_type;

   typedef struct packed {
      logic              vld;
      logic [31:0]       x;
      logic [31:0]       y;
      logic [31:0]       z;
      logic [31:0]       depth;
      logic [CNT_W-1:0]  count;
      logic              hit;
      logic [SLOT_W-1:0] hit_slot;
      logic [31:0]       hit_id;
      logic [31:0]       hit_depth;
      logic              pend_ok;
      logic [SQ_W-1:0]   sq_x;
      logic [SQ_W-1:0]   sq_y;
      logic [SQ_W-1:0]   sq_z;
      logic [SLOT_W-1:0] pend_slot;
      logic [31:0]       pend_id;
      logic [31:0]       pend_depth;
   } cmc_probe_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       x;
      logic [31:0]       y;
      logic [31:0]       z;
      logic [31:0]       depth;
      logic [31:0]       id;
   } cmc_wr_type;

   function automatic logic pend_near(input cmc_probe_type p, input logic [SQ_W-1:0] tsq);
      logic [SQ_W+1:0] sum;
      sum = (SQ_W+2)'(p.sq_x) + (SQ_W+2)'(p.sq_y) + (SQ_W+2)'(p.sq_z);
      return p.vld && p.pend_ok && (sum < (SQ_W+2)'(tsq));
   endfunction

endpackage
`default_nettype wire

[rtl/cmc_hash.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_hash
// Two-stage contact ID hash: per-axis magnitude times constant, then scale
// by 2^-16, restore sign, keep low 32 bits and XOR the three axes.
// ----------------------------------------------------------------------------
module cmc_hash
   import cmc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic [31:0] x,
   input  wire logic [31:0] y,
   input  wire logic [31:0] z,
   output logic      [31:0] id
);

   logic [2:0][31:0] raw;
   logic [2:0][31:0] k;
   logic [2:0][31:0] mag;
   logic [2:0][63:0] prod_in;
   logic [2:0][63:0] prod_ff;
   logic [2:0]       neg_ff;
   logic [2:0][31:0] axis;
   logic [31:0]      id_in;
   logic [31:0]      id_ff;

   assign raw = {z, y, x};
   assign k   = {HASH_Z, HASH_Y, HASH_X};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]     = raw[i][31] ? (32'd0 - raw[i]) : raw[i];
         prod_in[i] = 64'(mag[i]) * 64'(k[i]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      for (int i = 0; i < 3; i++) begin
         neg_ff[i] <= raw[i][31];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         axis[i] = neg_ff[i] ? (32'd0 - prod_ff[i][47:16]) : prod_ff[i][47:16];
      end
      id_in = axis[0] ^ axis[1] ^ axis[2];
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id = id_ff;

endmodule
`default_nettype wire

[rtl/cmc_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cmc_cell
// One stored contact. Resolves the previous cell's distance test, squares
// its own axis distances to the passing probe and hands the probe on.
// ----------------------------------------------------------------------------
module cmc_cell
   import cmc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [SLOT_W-1:0] idx,
   input  wire logic [THR_W-1:0]  thr,
   input  wire logic [SQ_W-1:0]   tsq,
   input  wire cmc_probe_type     prev_probe,
   input  wire cmc_wr_type        wr,
   output cmc_probe_type          probe_out
);

   logic [31:0]   ex_ff;
   logic [31:0]   ey_ff;
   logic [31:0]   ez_ff;
   logic [31:0]   edepth_ff;
   logic [31:0]   eid_ff;
   cmc_probe_type probe_ff;
   cmc_probe_type probe_in;

   logic          near_prev;
   logic          active;
   logic [2:0][32:0] diff;
   logic [2:0][32:0] adiff;
   logic [2:0]       in_range;

   always_comb begin
      diff[0] = {prev_probe.x[31], prev_probe.x} - {ex_ff[31], ex_ff};
      diff[1] = {prev_probe.y[31], prev_probe.y} - {ey_ff[31], ey_ff};
      diff[2] = {prev_probe.z[31], prev_probe.z} - {ez_ff[31], ez_ff};
      for (int i = 0; i < 3; i++) begin
         adiff[i]    = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
         in_range[i] = adiff[i] < 33'(thr);
      end
   end

   assign near_prev = pend_near(prev_probe, tsq);
   assign active    = CNT_W'(idx) < prev_probe.count;

   always_comb begin
      probe_in = prev_probe;
      if (!prev_probe.hit && near_prev) begin
         probe_in.hit       = 1'b1;
         probe_in.hit_slot  = prev_probe.pend_slot;
         probe_in.hit_id    = prev_probe.pend_id;
         probe_in.hit_depth = prev_probe.pend_depth;
      end
      probe_in.pend_ok    = active && (&in_range);
      probe_in.sq_x       = SQ_W'(adiff[0][THR_W-1:0]) * SQ_W'(adiff[0][THR_W-1:0]);
      probe_in.sq_y       = SQ_W'(adiff[1][THR_W-1:0]) * SQ_W'(adiff[1][THR_W-1:0]);
      probe_in.sq_z       = SQ_W'(adiff[2][THR_W-1:0]) * SQ_W'(adiff[2][THR_W-1:0]);
      probe_in.pend_slot  = idx;
      probe_in.pend_id    = eid_ff;
      probe_in.pend_depth = edepth_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff.vld <= 1'b0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && (wr.slot == idx)) begin
         ex_ff     <= wr.x;
         ey_ff     <= wr.y;
         ez_ff     <= wr.z;
         edepth_ff <= wr.depth;
         eid_ff    <= wr.id;
      end
   end

   assign probe_out = probe_ff;

endmodule
`default_nettype wire

[rtl/contact_point_merge_cache.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// contact_point_merge_cache
// Cache of up to MAX_SLOTS contact points. Each offered point merges into the
// first stored point closer than the threshold, else appends or replaces the
// last slot.
// A request is registered in probe0, walks the MAX_SLOTS cells one cell per
// cycle, then writes back and registers the result. One point is in flight:
// req_ready stays low until the write-back and while a result waits unread.
// Reset: clears the point count, handshake state and sets the threshold to
// 1311; stored entries hold no value until written.
// ----------------------------------------------------------------------------
module contact_point_merge_cache
   import cmc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cmc_req_type      req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cmc_rsp_type           rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [THR_W-1:0] csr_data
);

   logic              busy_ff;
   logic              rsp_valid_ff;
   cmc_rsp_type       rsp_ff;
   cmc_rsp_type       rsp_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [THR_W-1:0]  thr_ff;
   logic [SQ_W-1:0]   tsq_ff;
   cmc_probe_type     probe0_ff;
   cmc_probe_type     probe0_in;
   cmc_probe_type     chain [MAX_SLOTS+1];
   cmc_probe_type     last;
   cmc_wr_type        wr;
   logic [31:0]       hash_id;
   logic              req_xfer;
   logic              rsp_xfer;
   logic              near_last;
   logic              merged;
   logic              replaced;
   logic [SLOT_W-1:0] slot;
   logic [31:0]       new_id;
   logic [31:0]       new_depth;
   logic [31:0]       old_depth;

   assign rsp_xfer  = rsp_valid_ff && rsp_ready;
   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid && csr_ready) begin
         thr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      tsq_ff <= SQ_W'(thr_ff) * SQ_W'(thr_ff);
   end

   always_comb begin
      probe0_in         = probe0_ff;
      probe0_in.vld     = req_xfer;
      if (req_xfer) begin
         probe0_in.x       = req_data.pos_x;
         probe0_in.y       = req_data.pos_y;
         probe0_in.z       = req_data.pos_z;
         probe0_in.depth   = req_data.depth_in;
         probe0_in.count   = req_data.first ? '0 : count_ff;
         probe0_in.hit     = 1'b0;
         probe0_in.pend_ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe0_ff.vld <= 1'b0;
      end else begin
         probe0_ff <= probe0_in;
      end
   end

   cmc_hash u_hash (
      .clock (clock),
      .x     (probe0_ff.x),
      .y     (probe0_ff.y),
      .z     (probe0_ff.z),
      .id    (hash_id)
   );

   assign chain[0] = probe0_ff;

   for (genvar k = 0; k < MAX_SLOTS; k++) begin : g_cell
      cmc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .idx        (SLOT_W'(k)),
         .thr        (thr_ff),
         .tsq        (tsq_ff),
         .prev_probe (chain[k]),
         .wr         (wr),
         .probe_out  (chain[k+1])
      );
   end

   assign last      = chain[MAX_SLOTS];
   assign near_last = pend_near(last, tsq_ff);

   always_comb begin
      merged    = last.hit || near_last;
      replaced  = 1'b0;
      slot      = last.hit ? last.hit_slot : last.pend_slot;
      new_id    = last.hit ? last.hit_id : last.pend_id;
      old_depth = last.hit ? last.hit_depth : last.pend_depth;
      new_depth = ($signed(last.depth) > $signed(old_depth)) ? last.depth : old_depth;
      count_in  = last.count;
      if (!merged) begin
         new_id    = hash_id;
         new_depth = last.depth;
         if (last.count < CNT_FULL) begin
            slot     = last.count[SLOT_W-1:0];
            count_in = last.count + CNT_W'(1);
         end else begin
            slot     = SLOT_LAST;
            replaced = 1'b1;
         end
      end
   end

   always_comb begin
      wr.en    = last.vld;
      wr.slot  = slot;
      wr.x     = last.x;
      wr.y     = last.y;
      wr.z     = last.z;
      wr.depth = new_depth;
      wr.id    = new_id;
   end

   always_comb begin
      rsp_in.slot         = 2'(slot);
      rsp_in.merged       = merged;
      rsp_in.replaced     = replaced;
      rsp_in.point_id     = new_id;
      rsp_in.stored_depth = new_depth;
      rsp_in.point_count  = 3'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         if (req_xfer) begin
            busy_ff <= 1'b1;
         end else if (last.vld) begin
            busy_ff <= 1'b0;
         end
         if (last.vld) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (last.vld) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && rsp_valid_ff))
      else $error("result pending while a point is in flight");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("point count above capacity");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      last.vld |=> rsp_valid_ff)
      else $error("write-back without result");

   a_merge_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.merged && rsp_ff.replaced))
      else $error("merged and replaced both set");

endmodule
`default_nettype wire

[dv/tb_contact_point_merge_cache.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contact_point_merge_cache
// Self-checking bench for the contact point merge cache. A behavioral copy of
// the four-slot store predicts slot, merge, replace, ID, depth and count for
// every offered point. It runs directed merge/append/replace cases, threshold
// extremes, then random clustered manifolds over several thresholds, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_contact_point_merge_cache;
   import cmc_pkg::*;

   localparam int ITEMS_PER_SETTING = 105;
   localparam int DRAIN_LIMIT       = 20000;
   localparam int SHOWN_MISMATCHES  = 10;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   cmc_req_type      req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   cmc_rsp_type      rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [THR_W-1:0] csr_data  = THR_RESET;

   contact_point_merge_cache u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // contact store as the block should hold it
   logic signed [31:0] cache_x     [MAX_SLOTS];
   logic signed [31:0] cache_y     [MAX_SLOTS];
   logic signed [31:0] cache_z     [MAX_SLOTS];
   logic signed [31:0] cache_depth [MAX_SLOTS];
   logic        [31:0] cache_id    [MAX_SLOTS];
   int                 cache_count = 0;
   logic [THR_W-1:0]   thr_model   = THR_RESET;

   cmc_rsp_type contact_q [$];
   cmc_rsp_type want_rsp;

   int mismatch_cnt  = 0;
   int results_seen  = 0;
   int points_sent   = 0;
   int merge_cnt     = 0;
   int replace_cnt   = 0;
   int setting_cnt   = 1;
   int send_burst    = 0;

   function automatic logic [63:0] axis_gap(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? -d : d;
   endfunction

   function automatic logic [31:0] axis_hash(input logic signed [31:0] v,
                                             input logic [31:0] k);
      logic [31:0] mag;
      logic [63:0] prod;
      mag  = v[31] ? -v : v;
      prod = ({32'd0, mag} * {32'd0, k}) >> 16;
      if (v[31]) prod = -prod;
      return prod[31:0];
   endfunction

   function automatic logic is_close(input int idx, input cmc_req_type p);
      logic [63:0] t, dx, dy, dz;
      logic [65:0] sum;
      t  = 64'(thr_model);
      dx = axis_gap(cache_x[idx], p.pos_x);
      dy = axis_gap(cache_y[idx], p.pos_y);
      dz = axis_gap(cache_z[idx], p.pos_z);
      if (dx >= t || dy >= t || dz >= t) return 1'b0;
      sum = 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
      return sum < 66'(t * t);
   endfunction

   function automatic cmc_rsp_type merge_into_cache(input cmc_req_type p);
      cmc_rsp_type       r;
      int                hit;
      int                i;
      logic [SLOT_W-1:0] s;
      r   = '0;
      hit = -1;
      if (p.first) cache_count = 0;
      for (i = 0; i < cache_count; i++) begin
         if (hit < 0 && is_close(i, p)) hit = i;
      end
      if (hit >= 0) begin
         s = SLOT_W'(hit);
         r.merged = 1'b1;
         merge_cnt++;
         if ($signed(p.depth_in) > $signed(cache_depth[s])) cache_depth[s] = p.depth_in;
      end else begin
         if (cache_count < MAX_SLOTS) begin
            s = SLOT_W'(cache_count);
            cache_count++;
         end else begin
            s = SLOT_LAST;
            r.replaced = 1'b1;
            replace_cnt++;
         end
         cache_depth[s] = p.depth_in;
         cache_id[s]    = axis_hash(p.pos_x, HASH_X) ^ axis_hash(p.pos_y, HASH_Y) ^
                          axis_hash(p.pos_z, HASH_Z);
      end
      cache_x[s]     = p.pos_x;
      cache_y[s]     = p.pos_y;
      cache_z[s]     = p.pos_z;
      r.slot         = s;
      r.point_id     = cache_id[s];
      r.stored_depth = cache_depth[s];
      r.point_count  = 3'(cache_count);
      return r;
   endfunction

   function automatic cmc_req_type mk_point(input logic first, input logic signed [31:0] x,
                                            input logic signed [31:0] y,
                                            input logic signed [31:0] z,
                                            input logic signed [31:0] d);
      cmc_req_type p;
      p.first    = first;
      p.pos_x    = x;
      p.pos_y    = y;
      p.pos_z    = z;
      p.depth_in = d;
      return p;
   endfunction

   function automatic cmc_req_type random_point();
      return mk_point($urandom_range(0, 3) == 0, $urandom, $urandom, $urandom, $urandom);
   endfunction

   function automatic longint rand_off(input longint span);
      logic [63:0] r;
      r = {$urandom, $urandom};
      return longint'(r % 64'(2 * span + 1)) - span;
   endfunction

   function automatic int pick_gap();
      int r;
      if (send_burst > 0) begin
         send_burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         send_burst = $urandom_range(10, 40);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_cnt++;
      if (mismatch_cnt <= SHOWN_MISMATCHES)
         $display("%0t mismatch in %s: expected 0x%08h, got 0x%08h", $realtime, what,
                  want, got);
   endtask

   // send one point, leave valid high after the transfer
   task automatic send_point(input cmc_req_type p);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      contact_q.push_back(merge_into_cache(p));
      points_sent++;
   endtask

   task automatic idle_req();
      req_valid <= 1'b0;
   endtask

   task automatic wait_drain();
      int n;
      n = 0;
      while (contact_q.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] v);
      idle_req();
      wait_drain();
      repeat (8) @(posedge clock);
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      thr_model = v;
      setting_cnt++;
   endtask

   task automatic test_default_threshold();
      send_point(mk_point(1'b1, 0, 0, 0, 100));
      send_point(mk_point(1'b0, 1310, 0, 0, 50));
      send_point(mk_point(1'b0, 2621, 0, 0, 200));
      send_point(mk_point(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
      send_point(mk_point(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000));
      send_point(mk_point(1'b0, 32'sh80000000, 0, 0, -5));
      send_point(mk_point(1'b0, 32'sh80000064, 0, 0, 7));
      send_point(mk_point(1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFE, -1));
      // diagonal: each axis inside, summed squares outside, then first-slot priority
      send_point(mk_point(1'b1, 5000, 5000, 5000, 0));
      send_point(mk_point(1'b0, 5800, 5800, 5800, 0));
      send_point(mk_point(1'b0, 5400, 5400, 5400, 1));
   endtask

   task automatic test_threshold_extremes();
      write_threshold('0);
      send_point(mk_point(1'b1, 0, 0, 0, 0));
      send_point(mk_point(1'b0, 0, 0, 0, 1));
      write_threshold(THR_W'(1));
      send_point(mk_point(1'b1, 10, 10, 10, 0));
      send_point(mk_point(1'b0, 10, 10, 10, 5));
      send_point(mk_point(1'b0, 11, 10, 10, 6));
      write_threshold({THR_W{1'b1}});
      send_point(mk_point(1'b1, 0, 0, 0, 0));
      send_point(mk_point(1'b0, 32'sh7FFFFFFF, 0, 0, 0));
      send_point(mk_point(1'b0, 32'sh7FFFFFFE, 0, 0, 3));
      send_point(mk_point(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, -3));
      send_point(mk_point(1'b0, 32'shC0000000, 32'shC0000000, 32'shC0000000, -2));
   endtask

   task automatic test_random_manifolds();
      logic [THR_W-1:0] thr_list [6];
      cmc_req_type      anchor;
      cmc_req_type      pt;
      longint           span;
      longint           sp;
      longint           off;
      int               sent;
      int               len;
      int               k;
      thr_list = '{THR_RESET, THR_W'($urandom_range(2, 200000)), THR_W'($urandom),
                   {THR_W{1'b1}}, '0, THR_W'(1)};
      foreach (thr_list[ph]) begin
         write_threshold(thr_list[ph]);
         span = (thr_model == 0) ? 64'sd8 : longint'(thr_model);
         sent = 0;
         while (sent < ITEMS_PER_SETTING) begin
            if ($urandom_range(0, 4) == 0) begin
               send_point(random_point());
               sent++;
            end else begin
               anchor = random_point();
               len    = $urandom_range(1, 8);
               for (k = 0; k < len; k++) begin
                  pt       = anchor;
                  pt.first = (k == 0);
                  pt.depth_in = ($urandom_range(0, 1) == 0) ? $urandom :
                                $signed($urandom_range(0, 2000)) - 1000;
                  if (k > 0 && $urandom_range(0, 9) == 0) begin
                     off = longint'(thr_model) - longint'($urandom_range(0, 1));
                     if ($urandom_range(0, 1) == 1) off = -off;
                     case ($urandom_range(0, 2))
                        0: pt.pos_x = anchor.pos_x + 32'(off);
                        1: pt.pos_y = anchor.pos_y + 32'(off);
                        default: pt.pos_z = anchor.pos_z + 32'(off);
                     endcase
                  end else if (k > 0) begin
                     sp = ($urandom_range(0, 3) == 0) ? 2 * span : span;
                     pt.pos_x = anchor.pos_x + 32'(rand_off(sp));
                     pt.pos_y = anchor.pos_y + 32'(rand_off(sp));
                     pt.pos_z = anchor.pos_z + 32'(rand_off(sp));
                  end
                  send_point(pt);
                  sent++;
                  if ($urandom_range(0, 1) == 1) anchor = pt;
               end
            end
         end
      end
   endtask

   // result side: runs of ready, then stalls
   initial begin
      int run;
      int stall;
      @(posedge clock);
      forever begin
         run   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
         stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (contact_q.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_data.point_id);
         end else begin
            want_rsp = contact_q.pop_front();
            if (rsp_data.slot !== want_rsp.slot)
               report_mismatch("slot", 32'(want_rsp.slot), 32'(rsp_data.slot));
            if (rsp_data.merged !== want_rsp.merged)
               report_mismatch("merged", 32'(want_rsp.merged), 32'(rsp_data.merged));
            if (rsp_data.replaced !== want_rsp.replaced)
               report_mismatch("replaced", 32'(want_rsp.replaced), 32'(rsp_data.replaced));
            if (rsp_data.point_id !== want_rsp.point_id)
               report_mismatch("point_id", want_rsp.point_id, rsp_data.point_id);
            if (rsp_data.stored_depth !== want_rsp.stored_depth)
               report_mismatch("stored_depth", want_rsp.stored_depth, rsp_data.stored_depth);
            if (rsp_data.point_count !== want_rsp.point_count)
               report_mismatch("point_count", 32'(want_rsp.point_count),
                               32'(rsp_data.point_count));
         end
      end
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int leftover;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_default_threshold();
      test_threshold_extremes();
      test_random_manifolds();
      idle_req();
      wait_drain();
      repeat (20) @(posedge clock);
      leftover = contact_q.size();
      $display("Sent %0d contact points under %0d threshold settings; %0d results checked.",
               points_sent, setting_cnt, results_seen);
      $display("Predicted %0d merges and %0d last-slot replacements; %0d mismatches, %0d missing.",
               merge_cnt, replace_cnt, mismatch_cnt, leftover);
      if (mismatch_cnt == 0 && leftover == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
